FILE: hw/rtl/plob_pkg.sv
// Shared types and constants of the price level order book.
// Holds sizes, status and command codes, and the structs passed between the cells.
// No dependencies.
package plob_pkg;

	localparam int BOOK_LEVELS = 64;
	localparam int STAGE_DEPTH = 64;
	localparam int BCNT_W = $clog2(BOOK_LEVELS + 1);
	localparam int SCNT_W = $clog2(STAGE_DEPTH + 1);
	localparam int SIDX_W = (STAGE_DEPTH > 1) ? $clog2(STAGE_DEPTH) : 1;

	// result status codes
	localparam logic [2:0] ST_STAGED       = 3'd0;
	localparam logic [2:0] ST_APPLIED      = 3'd1;
	localparam logic [2:0] ST_WRONG_ID     = 3'd2;
	localparam logic [2:0] ST_BAD_LEVEL    = 3'd3;
	localparam logic [2:0] ST_DUPLICATE    = 3'd4;
	localparam logic [2:0] ST_BOOK_INVALID = 3'd5;
	localparam logic [2:0] ST_OVERFLOW     = 3'd6;

	// book side commands
	localparam logic [2:0] CMD_NOP    = 3'd0;
	localparam logic [2:0] CMD_LOAD   = 3'd1;
	localparam logic [2:0] CMD_CLEAR  = 3'd2;
	localparam logic [2:0] CMD_APPLY  = 3'd3;
	localparam logic [2:0] CMD_COMMIT = 3'd4;

	localparam logic       OP_SNAPSHOT = 1'b0;
	localparam logic       OP_UPDATE   = 1'b1;
	localparam logic       SIDE_BID    = 1'b0;
	localparam logic       SIDE_ASK    = 1'b1;

	localparam logic       CFG_VENUE      = 1'b0;
	localparam logic       CFG_INSTRUMENT = 1'b1;

	typedef logic signed [31:0] fx_t;

	typedef struct packed {
		logic [2:0] code;
		fx_t        price;
		fx_t        qty;
	} side_cmd_t;

	typedef struct packed {
		logic load;
		logic commit;
		logic del;
		logic set;
		logic ins;
		fx_t  price;
		fx_t  qty;
	} cell_act_t;

	typedef struct packed {
		logic side;
		fx_t  price;
		fx_t  qty;
	} stage_ent_t;

	typedef struct packed {
		logic shin;
		logic rot;
		logic setq;
		logic side;
		fx_t  price;
		fx_t  qty;
	} stage_cmd_t;

	typedef struct packed {
		logic        operation;
		logic [7:0]  msg_venue;
		logic [15:0] msg_instrument;
		logic        level_present;
		logic [1:0]  side;
		fx_t         price;
		fx_t         quantity;
		logic [31:0] sequence_req;
		logic        last_item;
	} item_t;

endpackage

FILE: hw/rtl/plob_in_if.sv
// Input channel of the order book: one level item per word.
// Uses plob_pkg for the fixed-point type.
interface plob_in_if;
	logic              valid;
	logic              ready;
	logic              operation;
	logic [7:0]        msg_venue;
	logic [15:0]       msg_instrument;
	logic              level_present;
	logic [1:0]        side;
	plob_pkg::fx_t     price;
	plob_pkg::fx_t     quantity;
	logic [31:0]       sequence_req;
	logic              last_item;

	modport source (output valid, operation, msg_venue, msg_instrument, level_present, side,
		price, quantity, sequence_req, last_item, input ready);
	modport sink (input valid, operation, msg_venue, msg_instrument, level_present, side,
		price, quantity, sequence_req, last_item, output ready);
endinterface

FILE: hw/rtl/plob_out_if.sv
// Result channel of the order book: status and top of book per word.
// Uses plob_pkg for the fixed-point type.
interface plob_out_if;
	logic          valid;
	logic          ready;
	logic [2:0]    status;
	logic          book_valid;
	logic          bid_present;
	plob_pkg::fx_t best_bid_price;
	plob_pkg::fx_t best_bid_qty;
	logic          ask_present;
	plob_pkg::fx_t best_ask_price;
	plob_pkg::fx_t best_ask_qty;
	logic          two_sided;
	logic          seq_known;
	logic [31:0]   last_seq;

	modport source (output valid, status, book_valid, bid_present, best_bid_price, best_bid_qty,
		ask_present, best_ask_price, best_ask_qty, two_sided, seq_known, last_seq,
		input ready);
	modport sink (input valid, status, book_valid, bid_present, best_bid_price, best_bid_qty,
		ask_present, best_ask_price, best_ask_qty, two_sided, seq_known, last_seq,
		output ready);
endinterface

FILE: hw/rtl/plob_level_cell.sv
// One price level of a sorted book side: committed copy and working copy.
// Depends on plob_pkg; instantiated by plob_side.
module plob_level_cell (
	input  logic                clk,
	input  plob_pkg::cell_act_t act,
	input  logic                desc,
	input  logic                valid,
	input  logic                prev_gt,
	input  plob_pkg::fx_t       left_p,
	input  plob_pkg::fx_t       left_q,
	input  plob_pkg::fx_t       right_p,
	input  plob_pkg::fx_t       right_q,
	output plob_pkg::fx_t       wp,
	output plob_pkg::fx_t       wq,
	output plob_pkg::fx_t       cp,
	output plob_pkg::fx_t       cq,
	output logic                gt,
	output logic                eq
);
	plob_pkg::fx_t wp_q, wq_q, cp_q, cq_q;

	// gt: this level sits ahead of the incoming price in book order
	assign gt = valid && (desc ? ($signed(wp_q) > $signed(act.price))
		: ($signed(wp_q) < $signed(act.price)));
	assign eq = valid && (wp_q == act.price);

	always_ff @(posedge clk) begin
		if (act.load) begin
			wp_q <= cp_q;
			wq_q <= cq_q;
		end else if (act.del && !gt && valid) begin
			wp_q <= right_p;
			wq_q <= right_q;
		end else if (act.set && eq) begin
			wq_q <= act.qty;
		end else if (act.ins && !gt) begin
			if (prev_gt) begin
				wp_q <= act.price;
				wq_q <= act.qty;
			end else begin
				wp_q <= left_p;
				wq_q <= left_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (act.commit) begin
			cp_q <= wp_q;
			cq_q <= wq_q;
		end
	end

	assign wp = wp_q;
	assign wq = wq_q;
	assign cp = cp_q;
	assign cq = cq_q;
endmodule

FILE: hw/rtl/plob_side.sv
// One side of the book: a row of level cells kept sorted, best level in cell 0.
// Depends on plob_pkg and plob_level_cell.
module plob_side (
	input  logic                       clk,
	input  logic                       arst_n,
	input  plob_pkg::side_cmd_t        cmd,
	input  logic                       desc,
	output logic                       ovf,
	output logic [plob_pkg::BCNT_W-1:0] ccnt,
	output plob_pkg::fx_t              best_p,
	output plob_pkg::fx_t              best_q
);
	localparam int N = plob_pkg::BOOK_LEVELS;

	plob_pkg::fx_t wp [N];
	plob_pkg::fx_t wq [N];
	plob_pkg::fx_t cp [N];
	plob_pkg::fx_t cq [N];
	logic [N-1:0] gt, eq, valid;
	logic [plob_pkg::BCNT_W-1:0] wcnt_q, ccnt_q;
	plob_pkg::cell_act_t act;
	logic apply, is_del, any_eq, full;

	assign apply  = cmd.code == plob_pkg::CMD_APPLY;
	assign is_del = cmd.qty == 32'sd0;
	assign any_eq = |eq;
	assign full   = wcnt_q == plob_pkg::BCNT_W'(N);

	always_comb begin
		act.load   = cmd.code == plob_pkg::CMD_LOAD;
		act.commit = cmd.code == plob_pkg::CMD_COMMIT;
		act.del    = apply && is_del && any_eq;
		act.set    = apply && !is_del && any_eq;
		act.ins    = apply && !is_del && !any_eq && !full;
		act.price  = cmd.price;
		act.qty    = cmd.qty;
	end

	assign ovf = apply && !is_del && !any_eq && full;

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic          pgt;
		plob_pkg::fx_t lp, lq, rp, rq;
		assign valid[i] = plob_pkg::BCNT_W'(i) < wcnt_q;
		if (i == 0) begin : g_first
			assign pgt = 1'b1;
			assign lp  = cmd.price;
			assign lq  = cmd.qty;
		end else begin : g_mid
			assign pgt = gt[i-1];
			assign lp  = wp[i-1];
			assign lq  = wq[i-1];
		end
		if (i == N - 1) begin : g_last
			assign rp = wp[i];
			assign rq = wq[i];
		end else begin : g_inner
			assign rp = wp[i+1];
			assign rq = wq[i+1];
		end
		plob_level_cell u_cell (
			.clk     (clk),
			.act     (act),
			.desc    (desc),
			.valid   (valid[i]),
			.prev_gt (pgt),
			.left_p  (lp),
			.left_q  (lq),
			.right_p (rp),
			.right_q (rq),
			.wp      (wp[i]),
			.wq      (wq[i]),
			.cp      (cp[i]),
			.cq      (cq[i]),
			.gt      (gt[i]),
			.eq      (eq[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcnt_q <= '0;
			ccnt_q <= '0;
		end else begin
			if (act.load)
				wcnt_q <= ccnt_q;
			else if (cmd.code == plob_pkg::CMD_CLEAR)
				wcnt_q <= '0;
			else if (act.del)
				wcnt_q <= wcnt_q - 1'b1;
			else if (act.ins)
				wcnt_q <= wcnt_q + 1'b1;
			if (act.commit)
				ccnt_q <= wcnt_q;
		end
	end

	assign ccnt   = ccnt_q;
	assign best_p = cp[0];
	assign best_q = cq[0];
endmodule

FILE: hw/rtl/plob_stage_cell.sv
// One entry of the message stage: side, price and quantity of a staged level.
// Depends on plob_pkg; instantiated by plob_stage.
module plob_stage_cell (
	input  logic                 clk,
	input  plob_pkg::stage_cmd_t cmd,
	input  logic                 valid,
	input  plob_pkg::stage_ent_t left,
	input  plob_pkg::stage_ent_t right,
	output plob_pkg::stage_ent_t ent,
	output logic                 match
);
	plob_pkg::stage_ent_t ent_q;

	assign match = valid && (ent_q.side == cmd.side) && (ent_q.price == cmd.price);

	always_ff @(posedge clk) begin
		if (cmd.shin)
			ent_q <= left;
		else if (cmd.rot)
			ent_q <= right;
		else if (cmd.setq && match)
			ent_q.qty <= cmd.qty;
	end

	assign ent = ent_q;
endmodule

FILE: hw/rtl/plob_stage.sv
// Message stage: a ring of stage cells. New levels shift in at cell 0;
// at commit the ring rotates so each entry passes cell 0 in turn.
// Depends on plob_pkg and plob_stage_cell.
module plob_stage (
	input  logic                        clk,
	input  plob_pkg::stage_cmd_t        cmd,
	input  logic [plob_pkg::SCNT_W-1:0] cnt,
	output plob_pkg::stage_ent_t        head,
	output logic                        any_match
);
	localparam int N = plob_pkg::STAGE_DEPTH;

	plob_pkg::stage_ent_t ent [N];
	logic [N-1:0] match;
	plob_pkg::stage_ent_t newent;

	assign newent = '{side: cmd.side, price: cmd.price, qty: cmd.qty};

	for (genvar i = 0; i < N; i++) begin : g_cell
		plob_pkg::stage_ent_t l, r;
		if (i == 0) begin : g_first
			assign l = newent;
		end else begin : g_mid
			assign l = ent[i-1];
		end
		if (i == N - 1) begin : g_last
			assign r = ent[0];
		end else begin : g_inner
			assign r = ent[i+1];
		end
		plob_stage_cell u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.valid (plob_pkg::SCNT_W'(i) < cnt),
			.left  (l),
			.right (r),
			.ent   (ent[i]),
			.match (match[i])
		);
	end

	assign head      = ent[0];
	assign any_match = |match;
endmodule

FILE: hw/rtl/price_level_order_book.sv
// Price level order book. Level items come in on item_in and each gives one word on
// result_out. An item that does not end its message passes S_CHECK and S_DONE. The
// last item of a message that is rejected also passes S_FINISH; one that commits
// passes S_LOAD, walks the stage ring twice (deletions, then insertions), one entry
// per cycle, and then S_COMMIT; the walk ends early if a side overflows. The next
// item is taken while the result word still waits. Each book side is a row of sorted
// level cells with a working copy that is swapped in only when the whole message fits.
// Registers are written through cfg_we/cfg_index.
module price_level_order_book (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata,
	plob_in_if.sink     item_in,
	plob_out_if.source  result_out
);
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_FINISH = 3'd2;
	localparam logic [2:0] S_LOAD   = 3'd3;
	localparam logic [2:0] S_WALK   = 3'd4;
	localparam logic [2:0] S_COMMIT = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0] state_q;
	logic [7:0] venue_q;
	logic [15:0] instr_q;
	plob_pkg::item_t it_q;
	logic msg_active_q, msg_op_q, valid_q, seen_q, pass_q;
	logic [2:0] msg_err_q, status_q;
	logic [31:0] seq_q;
	logic [plob_pkg::SCNT_W-1:0] scnt_q;
	logic [plob_pkg::SIDX_W-1:0] k_q;

	logic out_valid_q;
	logic [2:0] o_status_q;
	logic o_bv_q, o_bp_q, o_ap_q, o_two_q, o_seen_q;
	plob_pkg::fx_t o_bbp_q, o_bbq_q, o_bap_q, o_baq_q;
	logic [31:0] o_seq_q;

	plob_pkg::stage_cmd_t scmd;
	plob_pkg::stage_ent_t head;
	logic any_match;
	plob_pkg::side_cmd_t bid_cmd, ask_cmd;
	logic bid_ovf, ask_ovf;
	logic [plob_pkg::BCNT_W-1:0] bid_cnt, ask_cnt;
	plob_pkg::fx_t bid_p, bid_q, ask_p, ask_q;

	logic op_eff, take, out_free, accept;
	logic [2:0] err_n;

	assign accept   = item_in.valid && item_in.ready;
	assign out_free = !out_valid_q || result_out.ready;
	assign item_in.ready = state_q == S_IDLE;
	assign op_eff = msg_active_q ? msg_op_q : it_q.operation;
	assign take = (plob_pkg::SCNT_W'(k_q) < scnt_q) &&
		((head.qty == 32'sd0) == !pass_q);

	// item checks and stage command
	always_comb begin
		err_n = msg_err_q;
		scmd  = '{shin: 1'b0, rot: 1'b0, setq: 1'b0, side: it_q.side[0],
			price: it_q.price, qty: it_q.quantity};
		if (state_q == S_WALK)
			scmd.rot = 1'b1;
		if (state_q == S_CHECK && msg_err_q == plob_pkg::ST_STAGED) begin
			if (it_q.msg_venue != venue_q || it_q.msg_instrument != instr_q)
				err_n = plob_pkg::ST_WRONG_ID;
			else if (it_q.operation != op_eff)
				err_n = plob_pkg::ST_BAD_LEVEL;
			else if (it_q.level_present) begin
				if (it_q.side[1] || $signed(it_q.price) <= 32'sd0 ||
					(op_eff == plob_pkg::OP_SNAPSHOT ? $signed(it_q.quantity) <= 32'sd0
					: $signed(it_q.quantity) < 32'sd0))
					err_n = plob_pkg::ST_BAD_LEVEL;
				else if (any_match) begin
					if (op_eff == plob_pkg::OP_SNAPSHOT)
						err_n = plob_pkg::ST_DUPLICATE;
					else
						scmd.setq = 1'b1;
				end else if (scnt_q == plob_pkg::SCNT_W'(plob_pkg::STAGE_DEPTH))
					err_n = plob_pkg::ST_OVERFLOW;
				else
					scmd.shin = 1'b1;
			end
		end
	end

	// book side commands
	always_comb begin
		bid_cmd = '{code: plob_pkg::CMD_NOP, price: head.price, qty: head.qty};
		ask_cmd = '{code: plob_pkg::CMD_NOP, price: head.price, qty: head.qty};
		unique case (state_q)
			S_LOAD: begin
				bid_cmd.code = (msg_op_q == plob_pkg::OP_SNAPSHOT) ?
					plob_pkg::CMD_CLEAR : plob_pkg::CMD_LOAD;
				ask_cmd.code = bid_cmd.code;
			end
			S_WALK: begin
				if (take && head.side == plob_pkg::SIDE_BID)
					bid_cmd.code = plob_pkg::CMD_APPLY;
				if (take && head.side == plob_pkg::SIDE_ASK)
					ask_cmd.code = plob_pkg::CMD_APPLY;
			end
			S_COMMIT: begin
				bid_cmd.code = plob_pkg::CMD_COMMIT;
				ask_cmd.code = plob_pkg::CMD_COMMIT;
			end
			default: ;
		endcase
	end

	plob_stage u_stage (
		.clk       (clk),
		.cmd       (scmd),
		.cnt       (scnt_q),
		.head      (head),
		.any_match (any_match)
	);

	plob_side u_bid (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (bid_cmd),
		.desc   (1'b1),
		.ovf    (bid_ovf),
		.ccnt   (bid_cnt),
		.best_p (bid_p),
		.best_q (bid_q)
	);

	plob_side u_ask (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ask_cmd),
		.desc   (1'b0),
		.ovf    (ask_ovf),
		.ccnt   (ask_cnt),
		.best_p (ask_p),
		.best_q (ask_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			venue_q <= '0;
			instr_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				plob_pkg::CFG_VENUE:      venue_q <= cfg_wdata[7:0];
				plob_pkg::CFG_INSTRUMENT: instr_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			it_q <= '{operation: item_in.operation, msg_venue: item_in.msg_venue,
				msg_instrument: item_in.msg_instrument, level_present: item_in.level_present,
				side: item_in.side, price: item_in.price, quantity: item_in.quantity,
				sequence_req: item_in.sequence_req, last_item: item_in.last_item};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			msg_active_q <= 1'b0;
			msg_op_q     <= 1'b0;
			msg_err_q    <= plob_pkg::ST_STAGED;
			status_q     <= plob_pkg::ST_STAGED;
			scnt_q       <= '0;
			k_q          <= '0;
			pass_q       <= 1'b0;
			valid_q      <= 1'b0;
			seen_q       <= 1'b0;
			seq_q        <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_CHECK;
				end
				S_CHECK: begin
					msg_active_q <= 1'b1;
					msg_op_q     <= op_eff;
					msg_err_q    <= err_n;
					if (scmd.shin)
						scnt_q <= scnt_q + 1'b1;
					status_q <= err_n;
					state_q  <= it_q.last_item ? S_FINISH : S_DONE;
				end
				S_FINISH: begin
					if (msg_op_q == plob_pkg::OP_UPDATE && !valid_q) begin
						status_q <= plob_pkg::ST_BOOK_INVALID;
						state_q  <= S_DONE;
					end else if (msg_err_q != plob_pkg::ST_STAGED) begin
						status_q <= msg_err_q;
						state_q  <= S_DONE;
					end else
						state_q <= S_LOAD;
				end
				S_LOAD: begin
					k_q     <= '0;
					pass_q  <= 1'b0;
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (bid_ovf || ask_ovf) begin
						status_q <= plob_pkg::ST_OVERFLOW;
						state_q  <= S_DONE;
					end else if (k_q == plob_pkg::SIDX_W'(plob_pkg::STAGE_DEPTH - 1)) begin
						k_q <= '0;
						if (!pass_q)
							pass_q <= 1'b1;
						else
							state_q <= S_COMMIT;
					end else
						k_q <= k_q + 1'b1;
				end
				S_COMMIT: begin
					status_q <= plob_pkg::ST_APPLIED;
					seq_q    <= it_q.sequence_req;
					seen_q   <= 1'b1;
					if (msg_op_q == plob_pkg::OP_SNAPSHOT)
						valid_q <= 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			// message closes once its last item has been decided
			if (state_q == S_DONE && out_free && it_q.last_item) begin
				msg_active_q <= 1'b0;
				msg_err_q    <= plob_pkg::ST_STAGED;
				scnt_q       <= '0;
			end
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == S_DONE && out_free)
			out_valid_q <= 1'b1;
		else if (result_out.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			o_status_q <= status_q;
			o_bv_q     <= valid_q;
			o_bp_q     <= valid_q && bid_cnt != '0;
			o_bbp_q    <= (valid_q && bid_cnt != '0) ? bid_p : 32'sd0;
			o_bbq_q    <= (valid_q && bid_cnt != '0) ? bid_q : 32'sd0;
			o_ap_q     <= valid_q && ask_cnt != '0;
			o_bap_q    <= (valid_q && ask_cnt != '0) ? ask_p : 32'sd0;
			o_baq_q    <= (valid_q && ask_cnt != '0) ? ask_q : 32'sd0;
			o_two_q    <= valid_q && bid_cnt != '0 && ask_cnt != '0;
			o_seen_q   <= seen_q;
			o_seq_q    <= seq_q;
		end
	end

	assign result_out.valid          = out_valid_q;
	assign result_out.status         = o_status_q;
	assign result_out.book_valid     = o_bv_q;
	assign result_out.bid_present    = o_bp_q;
	assign result_out.best_bid_price = o_bbp_q;
	assign result_out.best_bid_qty   = o_bbq_q;
	assign result_out.ask_present    = o_ap_q;
	assign result_out.best_ask_price = o_bap_q;
	assign result_out.best_ask_qty   = o_baq_q;
	assign result_out.two_sided      = o_two_q;
	assign result_out.seq_known      = o_seen_q;
	assign result_out.last_seq       = o_seq_q;

	a_stage_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scnt_q <= plob_pkg::SCNT_W'(plob_pkg::STAGE_DEPTH))
		else $error("stage count beyond depth");

	a_valid_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(valid_q))
		else $error("book validity dropped");

	a_two_sided: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (o_two_q == (o_bp_q && o_ap_q)))
		else $error("two_sided disagrees with side presence");
endmodule
